FILE: hdl/bmpt_pkg.sv
// shared constants, motion codes and control structs for the blind position tracker
package bmpt_pkg;

    localparam int NOW_W   = 32;
    localparam int TRAV_W  = 16;
    localparam int PCT_W   = 7;
    localparam int MOT_W   = 2;
    localparam int SUM_W   = NOW_W + 2;
    localparam int PROD_W  = TRAV_W + PCT_W;
    localparam int QUO_W   = PCT_W;
    localparam int RND_W   = PCT_W + 1;

    // reciprocal for the rounding step, exact for any 7-bit value and step up to 50
    localparam int RECIP_SHIFT = 14;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int RPROD_W     = QUO_W + RECIP_W;

    localparam logic [TRAV_W-1:0] FULL_TRAVEL_RST = 16'd10000;
    localparam int                ROUND_STEP_DEF  = 5;
    localparam int                ROUND_HALF      = 2;
    localparam int                PCT_FULL        = 100;

    localparam logic [MOT_W-1:0] MOT_STOP  = 2'd0;
    localparam logic [MOT_W-1:0] MOT_UP    = 2'd1;
    localparam logic [MOT_W-1:0] MOT_DOWN  = 2'd2;
    localparam logic [MOT_W-1:0] MOT_STOP2 = 2'd3;

    typedef struct packed {
        logic idle;
        logic sum_en;
        logic clamp_en;
        logic mul_en;
        logic div_load_q;
        logic quo_load;
        logic div_step;
        logic round_en;
        logic emit;
    } bmpt_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic need_update;
        logic full_zero;
        logic out_free;
    } bmpt_sts_t;

endpackage

FILE: hdl/bmpt_in_if.sv
// command item channel: up and down levels with a millisecond timestamp
interface bmpt_in_if;
    logic                        valid;
    logic                        ready;
    logic                        up_cmd;
    logic                        down_cmd;
    logic [bmpt_pkg::NOW_W-1:0]  now_ms;

    modport source (output valid, up_cmd, down_cmd, now_ms, input ready);
    modport sink   (input valid, up_cmd, down_cmd, now_ms, output ready);
endinterface

FILE: hdl/bmpt_out_if.sv
// result channel: motion state, position and change flag
interface bmpt_out_if;
    logic                        valid;
    logic                        ready;
    logic [bmpt_pkg::MOT_W-1:0]  motion;
    logic [bmpt_pkg::PCT_W-1:0]  position_pct;
    logic                        motion_changed;

    modport source (output valid, motion, position_pct, motion_changed, input ready);
    modport sink   (input valid, motion, position_pct, motion_changed, output ready);
endinterface

FILE: hdl/bmpt_cfg_if.sv
// configuration write channel for the full travel time
interface bmpt_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [bmpt_pkg::TRAV_W-1:0] full_travel_ms;

    modport source (output valid, full_travel_ms, input ready);
    modport sink   (input valid, full_travel_ms, output ready);
endinterface

FILE: hdl/bmpt_div.sv
// restoring divider, one quotient bit per step, remainder kept below the divisor
module bmpt_div (
    input  logic                        clk,
    input  logic                        load,
    input  logic                        step,
    input  logic [bmpt_pkg::TRAV_W-1:0] hi_init,
    input  logic [bmpt_pkg::QUO_W-1:0]  lo_init,
    input  logic [bmpt_pkg::TRAV_W-1:0] divisor,
    output logic [bmpt_pkg::QUO_W-1:0]  quo
);
    import bmpt_pkg::*;

    logic [TRAV_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0]  lo_reg, lo_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [TRAV_W-1:0] div_reg;
    logic [TRAV_W:0]   trial;
    logic [TRAV_W:0]   diff;
    logic              fits;

    always_comb
    begin
        trial    = {rem_reg, lo_reg[QUO_W-1]};
        diff     = trial - {1'b0, div_reg};
        fits     = (trial >= {1'b0, div_reg});
        rem_next = fits ? diff[TRAV_W-1:0] : trial[TRAV_W-1:0];
        lo_next  = {lo_reg[QUO_W-2:0], 1'b0};
        quo_next = {quo_reg[QUO_W-2:0], fits};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= hi_init;
            lo_reg  <= lo_init;
            quo_reg <= '0;
            div_reg <= divisor;
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            lo_reg  <= lo_next;
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;
endmodule

FILE: hdl/bmpt_datapath.sv
// motion machine, travel accumulator, percentage arithmetic and result register
module bmpt_datapath #(
    parameter int ROUND_STEP = bmpt_pkg::ROUND_STEP_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    bmpt_in_if.sink              item,
    bmpt_out_if.source           result,
    bmpt_cfg_if.sink             cfg,
    input  bmpt_pkg::bmpt_cmd_t  cmd,
    output bmpt_pkg::bmpt_sts_t  sts
);
    import bmpt_pkg::*;

    localparam logic [RECIP_W-1:0] RECIP_MUL =
        RECIP_W'(((1 << RECIP_SHIFT) + ROUND_STEP - 1) / ROUND_STEP);

    logic [TRAV_W-1:0] full_reg;
    logic [MOT_W-1:0]  motion_reg, motion_next;
    logic [MOT_W-1:0]  prev_reg;
    logic              moving_reg;
    logic [NOW_W-1:0]  start_reg;
    logic [TRAV_W-1:0] travel_reg;
    logic [PCT_W-1:0]  percent_reg;
    logic [NOW_W-1:0]  elapsed_reg;
    logic              dir_up_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [QUO_W-1:0]  x_reg;
    logic [QUO_W-1:0]  rq_reg;
    logic              changed_reg;
    logic              out_valid_reg;
    logic [MOT_W-1:0]  out_motion_reg;
    logic [PCT_W-1:0]  out_pct_reg;
    logic              out_changed_reg;

    logic               accept;
    logic               changed;
    logic               to_stop;
    logic               upd;
    logic               upd_dir_up;
    logic [SUM_W-1:0]   travel_ext, elapsed_ext;
    logic [TRAV_W-1:0]  clamped;
    logic [QUO_W-1:0]   div_quo;
    logic [RPROD_W-1:0] rprod;
    logic [RND_W-1:0]   r8, x8, p8;
    logic [PCT_W-1:0]   pct_rounded;

    assign accept = cmd.idle && item.valid;

    // next motion state from the command levels
    always_comb
    begin
        motion_next = motion_reg;
        case (motion_reg)
            MOT_STOP:
            begin
                if (item.up_cmd)
                    motion_next = MOT_UP;
                if (item.down_cmd)
                    motion_next = MOT_DOWN;
            end
            MOT_UP:
            begin
                if (!item.up_cmd && !item.down_cmd)
                    motion_next = MOT_STOP;
                if (!item.up_cmd && item.down_cmd)
                    motion_next = MOT_STOP2;
            end
            MOT_DOWN:
            begin
                if (!item.up_cmd && !item.down_cmd)
                    motion_next = MOT_STOP;
                if (item.up_cmd && !item.down_cmd)
                    motion_next = MOT_STOP2;
            end
            default:
            begin
                if (!item.up_cmd && !item.down_cmd)
                    motion_next = MOT_STOP;
            end
        endcase
    end

    always_comb
    begin
        changed = (motion_next != motion_reg);
        to_stop = (motion_next == MOT_STOP) || (motion_next == MOT_STOP2);
        if (to_stop)
        begin
            upd        = changed && ((prev_reg == MOT_UP) || (prev_reg == MOT_DOWN));
            upd_dir_up = (prev_reg == MOT_UP);
        end
        else
        begin
            upd        = changed && moving_reg;
            upd_dir_up = (motion_next == MOT_UP);
        end
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg   <= FULL_TRAVEL_RST;
            motion_reg <= MOT_STOP;
            prev_reg   <= MOT_STOP;
            moving_reg <= 1'b0;
            start_reg  <= '0;
        end
        else
        begin
            if (cfg.valid)
                full_reg <= cfg.full_travel_ms;
            if (accept && changed)
            begin
                motion_reg <= motion_next;
                prev_reg   <= motion_next;
                moving_reg <= !to_stop;
                if (!to_stop)
                    start_reg <= item.now_ms;
            end
        end
    end

    // elapsed time is taken against the stamp before it is replaced
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            elapsed_reg <= item.now_ms - start_reg;
            dir_up_reg  <= upd_dir_up;
            changed_reg <= changed;
        end
    end

    assign travel_ext  = SUM_W'(travel_reg);
    assign elapsed_ext = SUM_W'(elapsed_reg);

    // quotient by the rounding step through a reciprocal, exact over the percentage range
    assign rprod = RPROD_W'(div_quo) * RPROD_W'(RECIP_MUL);

    always_ff @(posedge clk)
    begin
        if (cmd.sum_en)
            sum_reg <= dir_up_reg ? (travel_ext + elapsed_ext) : (travel_ext - elapsed_ext);
        if (cmd.mul_en)
            prod_reg <= PROD_W'(travel_reg) * PROD_W'(PCT_FULL);
        if (cmd.quo_load)
        begin
            x_reg  <= div_quo;
            rq_reg <= rprod[RECIP_SHIFT +: QUO_W];
        end
    end

    always_comb
    begin
        if (sum_reg[SUM_W-1])
            clamped = '0;
        else if (sum_reg[SUM_W-2:0] > (SUM_W-1)'(full_reg))
            clamped = full_reg;
        else
            clamped = sum_reg[TRAV_W-1:0];
    end

    always_comb
    begin
        x8 = RND_W'(x_reg);
        r8 = x8 - RND_W'(rq_reg) * RND_W'(ROUND_STEP);
        if (r8 > RND_W'(ROUND_HALF))
            p8 = x8 + RND_W'(ROUND_STEP) - r8;
        else
            p8 = x8 - r8;
        if (p8 > RND_W'(PCT_FULL))
            pct_rounded = PCT_W'(PCT_FULL);
        else
            pct_rounded = p8[PCT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            travel_reg  <= '0;
            percent_reg <= '0;
        end
        else
        begin
            if (cmd.clamp_en)
            begin
                travel_reg <= clamped;
                if (full_reg == '0)
                    percent_reg <= '0;
            end
            if (cmd.round_en)
                percent_reg <= pct_rounded;
        end
    end

    // travel*100 / full
    bmpt_div u_div (
        .clk     (clk),
        .load    (cmd.div_load_q),
        .step    (cmd.div_step),
        .hi_init (prod_reg[PROD_W-1:QUO_W]),
        .lo_init (prod_reg[QUO_W-1:0]),
        .divisor (full_reg),
        .quo     (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_motion_reg  <= motion_reg;
            out_pct_reg     <= percent_reg;
            out_changed_reg <= changed_reg;
        end
    end

    assign item.ready            = cmd.idle;
    assign result.valid          = out_valid_reg;
    assign result.motion         = out_motion_reg;
    assign result.position_pct   = out_pct_reg;
    assign result.motion_changed = out_changed_reg;

    assign sts.in_valid    = item.valid;
    assign sts.need_update = upd;
    assign sts.full_zero   = (full_reg == '0);
    assign sts.out_free    = !out_valid_reg || result.ready;
endmodule

FILE: hdl/bmpt_ctrl.sv
// sequencer: update, clamp, multiply, divider pass, rounding, result hand-off
module bmpt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bmpt_pkg::bmpt_sts_t  sts,
    output bmpt_pkg::bmpt_cmd_t  cmd
);
    import bmpt_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SUM   = 4'd1;
    localparam logic [3:0] ST_CLAMP = 4'd2;
    localparam logic [3:0] ST_MUL   = 4'd3;
    localparam logic [3:0] ST_LOADQ = 4'd4;
    localparam logic [3:0] ST_DIVQ  = 4'd5;
    localparam logic [3:0] ST_XLOAD = 4'd6;
    localparam logic [3:0] ST_ROUND = 4'd7;
    localparam logic [3:0] ST_EMIT  = 4'd8;

    localparam int CNT_W = $clog2(QUO_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.idle = 1'b1;
                if (sts.in_valid)
                    state_next = sts.need_update ? ST_SUM : ST_EMIT;
            end
            ST_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                cmd.clamp_en = 1'b1;
                state_next   = sts.full_zero ? ST_EMIT : ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_LOADQ;
            end
            ST_LOADQ:
            begin
                cmd.div_load_q = 1'b1;
                cnt_next       = '0;
                state_next     = ST_DIVQ;
            end
            ST_DIVQ:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                    state_next = ST_XLOAD;
            end
            ST_XLOAD:
            begin
                cmd.quo_load = 1'b1;
                state_next   = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end
endmodule

FILE: hdl/blind_motion_position_tracker.sv
// top level of the blind position tracker: sequencer and datapath
//
//  channel  dir  handshake      payload
//  item     in   valid/ready    up_cmd, down_cmd, now_ms[31:0]
//  result   out  valid/ready    motion[1:0], position_pct[6:0], motion_changed
//  cfg      in   valid/ready    full_travel_ms[15:0]
//
//  an item with no position update goes from idle straight to emit, which waits for a free
//  result register; an item that moves the travel total passes sum, clamp, multiply,
//  the seven-step restoring divider and rounding; zero full travel skips from clamp to emit
//  rst_n is asynchronous: motion stop, travel and position zero, full travel 10000 ms
//  the result register holds while result.ready is low; the next item is taken meanwhile
module blind_motion_position_tracker #(
    parameter int ROUND_STEP = bmpt_pkg::ROUND_STEP_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bmpt_in_if.sink     item,
    bmpt_out_if.source  result,
    bmpt_cfg_if.sink    cfg
);
    import bmpt_pkg::*;

    bmpt_cmd_t cmd;
    bmpt_sts_t sts;

    bmpt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    bmpt_datapath #(
        .ROUND_STEP (ROUND_STEP)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg),
        .cmd    (cmd),
        .sts    (sts)
    );
endmodule
